// ===== src/wsu_pkg.sv =====
package wsu_pkg;

  localparam int unsigned KeyBytes = 4;
  localparam int unsigned KeyIdxW = $clog2(KeyBytes);

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic       length_error;
  } result_t;

endpackage

// ===== src/wsu_in_reg.sv =====
module wsu_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       busy_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The held item can only move on when the parser advances.
  assign in_stall_o = valid_q && !advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign busy_o = valid_q;
  assign byte_o = byte_q;

endmodule

// ===== src/wsu_parser.sv =====
module wsu_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  output wsu_pkg::result_t      res_o
);

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_LEN    = 4'd1;
  localparam logic [3:0] PH_EXT_HI = 4'd2;
  localparam logic [3:0] PH_EXT_LO = 4'd3;
  localparam logic [3:0] PH_KEY0   = 4'd4;
  localparam logic [3:0] PH_KEY1   = 4'd5;
  localparam logic [3:0] PH_KEY2   = 4'd6;
  localparam logic [3:0] PH_KEY3   = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;

  logic [3:0]                   phase_q, phase_d;
  logic [7:0]                   key_q [wsu_pkg::KeyBytes];
  logic [15:0]                  rem_q, rem_d;
  logic [wsu_pkg::KeyIdxW-1:0]  kidx_q, kidx_d;
  logic                         key_we;
  logic [wsu_pkg::KeyIdxW-1:0]  key_waddr;
  logic [6:0]                   len;
  logic [15:0]                  rem_dec;
  wsu_pkg::result_t             res;

  assign len       = byte_i[6:0];
  assign rem_dec   = rem_q - 16'd1;
  assign key_waddr = phase_q[wsu_pkg::KeyIdxW-1:0];

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    kidx_d  = kidx_q;
    key_we  = 1'b0;
    res     = '0;
    case (phase_q)
      PH_LEN: begin
        if (len == wsu_pkg::LEN_EXT64) begin
          phase_d          = PH_HDR;
          res.valid        = 1'b1;
          res.length_error = 1'b1;
        end else if (len == wsu_pkg::LEN_EXT16) begin
          phase_d = PH_EXT_HI;
        end else begin
          rem_d   = {9'd0, len};
          phase_d = PH_KEY0;
        end
      end
      PH_EXT_HI: begin
        rem_d   = {byte_i, 8'd0};
        phase_d = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        rem_d   = {rem_q[15:8], byte_i};
        phase_d = PH_KEY0;
      end
      PH_KEY0, PH_KEY1, PH_KEY2: begin
        key_we  = 1'b1;
        phase_d = phase_q + 4'd1;
      end
      PH_KEY3: begin
        key_we = 1'b1;
        kidx_d = '0;
        if (rem_q == 16'd0) begin
          phase_d           = PH_HDR;
          res.valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.empty_frame   = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        kidx_d            = kidx_q + 1'b1;
        rem_d             = rem_dec;
        res.valid         = 1'b1;
        res.payload_byte  = byte_i ^ key_q[kidx_q];
        res.last_of_frame = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_d = PH_HDR;
        end
      end
      default: begin
        // The first header byte, and any unused code, leads to the length byte.
        phase_d = PH_LEN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      rem_q   <= '0;
      kidx_q  <= '0;
      for (int i = 0; i < wsu_pkg::KeyBytes; i++) begin
        key_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      kidx_q  <= kidx_d;
      if (key_we) begin
        key_q[key_waddr] <= byte_i;
      end
    end
  end

  always_comb begin
    res_o       = res;
    res_o.valid = res.valid && fire_i;
  end

`ifndef SYNTHESIS
  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != 16'd0)
    else $error("payload phase entered with nothing left to receive");

  a_key3_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_KEY3 |=> phase_q == PH_DATA || phase_q == PH_HDR)
    else $error("last key byte did not lead to payload or a new frame");

  a_error_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.length_error |=> phase_q == PH_HDR)
    else $error("length error did not restart frame parsing");

  a_result_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> fire_i && phase_q != PH_HDR)
    else $error("result produced without an item being processed");
`endif

endmodule

// ===== src/wsu_out_reg.sv =====
module wsu_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wsu_pkg::result_t res_i,
  output logic             advance_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             last_of_frame_o,
  output logic             empty_frame_o,
  output logic             length_error_o
);

  logic             valid_q, valid_d;
  wsu_pkg::result_t res_q;

  // The register can take a new result when empty or when its item leaves now.
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = res_i.valid;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign last_of_frame_o = res_q.last_of_frame;
  assign empty_frame_o   = res_q.empty_frame;
  assign length_error_o  = res_q.length_error;

endmodule

// ===== src/websocket_frame_unmasker.sv =====
// WebSocket frame unmasker.
// The input channel (in_valid_i, in_stall_o, rx_byte_i) takes the received
// frame stream one byte per item, frames following one another directly.
// The output channel (out_valid_o, out_stall_i and the result fields) gives
// one item per payload byte, unmasked with the frame's four-byte key, with
// last_of_frame_o on the final byte. A zero-length frame gives one item with
// empty_frame_o and last_of_frame_o set; length code 127 gives one item with
// length_error_o set, after which a new frame is expected.
// Otherwise, header, length and key bytes give no output item.
// out_valid_o rises once a byte that gives an item has been accepted: the byte
// is held in the input register and its result is then loaded into the result
// register. One byte is accepted every cycle while the receiver does not stall;
// the combinational parser update between the two registers allows that rate.
// While the receiver stalls, the result register holds its item and the
// input register holds one more byte, then in_stall_o rises.
// Reset empties both registers and returns the parser to the first header
// byte with the key and length cleared.
module websocket_frame_unmasker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       last_of_frame_o,
  output logic       empty_frame_o,
  output logic       length_error_o
);

  logic             advance;
  logic             busy;
  logic             fire;
  logic [7:0]       byte_q;
  wsu_pkg::result_t res;

  assign fire = busy && advance;

  wsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .busy_o     (busy),
    .byte_o     (byte_q)
  );

  wsu_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .res_o  (res)
  );

  wsu_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (fire),
    .res_i           (res),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .last_of_frame_o (last_of_frame_o),
    .empty_frame_o   (empty_frame_o),
    .length_error_o  (length_error_o)
  );

endmodule
